// ----- sv/fir_convolution_sixteen_tap_unit_macros.svh -----
// Assertion macros shared by the FIR convolution unit.
`ifndef FIR_CONVOLUTION_SIXTEEN_TAP_UNIT_MACROS_SVH
`define FIR_CONVOLUTION_SIXTEEN_TAP_UNIT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define FIR16_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("FIR16 assertion failed");

// Checked on every rising edge of clk_i, also during reset.
`define FIR16_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("FIR16 assertion failed");

`endif

// ----- sv/fir16_pkg.sv -----
// Types, widths and tap constants of the FIR convolution unit.
package fir16_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 36;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Signed Q2.14 tap k of a filter with the given number of taps, rounded to
  // nearest with ties away from zero.
  function automatic coef_t tap_value(input int k, input int taps);
    logic [63:0] mag;
    logic [COEF_W-1:0] mag_c;
    coef_t tap;
    mag = '0;
    if ((k < taps - 2) && (k <= 20)) begin
      mag = mag + (64'd1 << (20 - k));
    end
    if ((k >= 2) && (k - 2 <= 20)) begin
      mag = mag + (64'd1 << (22 - k));
    end
    mag = (mag + 64'd32) >> 6;
    mag_c = mag[COEF_W-1:0];
    if (k[0]) begin
      tap = -$signed(mag_c);
    end else begin
      tap = $signed(mag_c);
    end
    return tap;
  endfunction

endpackage

// ----- sv/fir16_in_if.sv -----
// Input channel of the FIR convolution unit: one sample and its block flag.
interface fir16_in_if;
  logic                valid;
  logic                ready;
  fir16_pkg::sample_t  sample;
  logic                end_of_block;

  modport source (output valid, output sample, output end_of_block, input ready);
  modport sink   (input valid, input sample, input end_of_block, output ready);
endinterface

// ----- sv/fir16_out_if.sv -----
// Output channel of the FIR convolution unit: one filtered value and its flag.
interface fir16_out_if;
  logic             valid;
  logic             ready;
  fir16_pkg::acc_t  filtered;
  logic             final_output;

  modport source (output valid, output filtered, output final_output, input ready);
  modport sink   (input valid, input filtered, input final_output, output ready);
endinterface

// ----- sv/fir_convolution_sixteen_tap_unit.sv -----
// Top level of the FIR convolution unit: cell chain, flush control and output stage.
//
// Usage: samples arrive on in_i (valid/ready); one filtered value per sample
// leaves on out_o (valid/ready), in order. A sample with end_of_block set is
// followed by TAPS-1 flush outputs computed as if zeros were fed in; the
// last of these has final_output set and leaves the filter state all zero.
// A sample's output is registered and valid in the cycle after its transfer.
// Throughput: one sample per cycle while out_o is not stalled; after a sample
// with end_of_block the input is not ready for TAPS-1 output transfers while
// the flush runs. Each cycle's rate is set by the chain of TAPS cells, each
// holding one partial sum and passing it to its neighbor whenever fire is high.
// Reset clears all partial sums, the output stage and the flush counter.
// When the receiver stalls, the output register holds its value and the
// chain stops, so in_i.ready drops until the held output is taken.
`include "fir_convolution_sixteen_tap_unit_macros.svh"

module fir_convolution_sixteen_tap_unit #(
  parameter int TAPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fir16_in_if.sink    in_i,
  fir16_out_if.source out_o
);
  import fir16_pkg::*;

  localparam int CntW = (TAPS > 2) ? $clog2(TAPS) : 1;

  logic            advance;
  logic            fire;
  logic            flushing;
  logic            accept;
  sample_t         cell_x;
  logic [CntW-1:0] flush_cnt_d;
  logic [CntW-1:0] flush_cnt_q;
  logic            out_valid_d;
  logic            out_valid_q;
  logic            final_d;
  logic            final_q;
  acc_t            sums [TAPS+1];

  assign flushing = (flush_cnt_q != '0);
  assign advance  = !out_valid_q || out_o.ready;
  assign accept   = advance && !flushing && in_i.valid;
  assign fire     = advance && (flushing || in_i.valid);
  assign cell_x   = flushing ? '0 : in_i.sample;

  assign in_i.ready = advance && !flushing;

  assign sums[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    fir16_cell #(
      .Coef(tap_value(k, TAPS))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (fire),
      .sample_i(cell_x),
      .sum_i   (sums[k+1]),
      .sum_o   (sums[k])
    );
  end

  always_comb begin
    flush_cnt_d = flush_cnt_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      if (flushing) begin
        flush_cnt_d = flush_cnt_q - CntW'(1);
        final_d     = (flush_cnt_q == CntW'(1));
      end else begin
        final_d = 1'b0;
        if (in_i.end_of_block) begin
          flush_cnt_d = CntW'(TAPS - 1);
        end
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_cnt_q <= '0;
      out_valid_q <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      flush_cnt_q <= flush_cnt_d;
      out_valid_q <= out_valid_d;
      final_q     <= final_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.filtered     = sums[0];
  assign out_o.final_output = final_q;

  `FIR16_ASSERT(a_no_input_during_flush, flushing |-> !in_i.ready)
  `FIR16_ASSERT(a_flush_starts, (accept && in_i.end_of_block) |=> (flush_cnt_q == CntW'(TAPS - 1)))
  `FIR16_ASSERT(a_final_ends_flush, (out_valid_q && final_q) |-> !flushing)
  `FIR16_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_q && !flushing))

endmodule

// ----- sv/fir16_cell.sv -----
// One tap cell of the transposed FIR chain: product plus the neighbor's partial sum.
module fir16_cell #(
  parameter fir16_pkg::coef_t Coef = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fir16_pkg::sample_t sample_i,
  input  fir16_pkg::acc_t   sum_i,
  output fir16_pkg::acc_t   sum_o
);
  import fir16_pkg::*;

  prod_t prod;
  acc_t  sum_d;
  acc_t  sum_q;

  assign prod  = PROD_W'(sample_i) * PROD_W'(Coef);
  assign sum_d = ACC_W'(prod) + sum_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the sixteen-tap FIR convolution unit.
`timescale 1ns / 100ps

module testbench;
  import fir16_pkg::*;

  localparam int TAP_COUNT   = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    acc_t filtered;
    logic final_output;
  } fir_result_t;

  logic clk_i;
  logic rst_ni;

  fir16_in_if  in_ch ();
  fir16_out_if out_ch ();

  fir_convolution_sixteen_tap_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  int impulse [TAP_COUNT] = '{16384, -8192, 20480, -10240, 5120, -2560, 1280, -640,
                              320, -160, 80, -40, 20, -10, 4, -2};
  sample_t delay_line [TAP_COUNT-1];
  fir_result_t pending_outputs [$];

  bit sender_bursts;
  bit receiver_bursts;
  int samples_sent;
  int blocks_sent;
  int outputs_checked;
  int mismatches;
  int quiet_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic acc_t convolve_next(sample_t newest);
    longint acc;
    acc = longint'(impulse[0]) * longint'(newest);
    for (int k = 1; k < TAP_COUNT; k++) begin
      acc += longint'(impulse[k]) * longint'(delay_line[k-1]);
    end
    return acc[ACC_W-1:0];
  endfunction

  function automatic void shift_delay_line(sample_t newest);
    for (int k = TAP_COUNT - 2; k > 0; k--) begin
      delay_line[k] = delay_line[k-1];
    end
    delay_line[0] = newest;
  endfunction

  function automatic void predict_outputs(sample_t s, logic eob);
    fir_result_t r;
    r.filtered = convolve_next(s);
    r.final_output = 1'b0;
    pending_outputs.push_back(r);
    shift_delay_line(s);
    if (eob) begin
      for (int k = 0; k < TAP_COUNT - 1; k++) begin
        r.filtered = convolve_next('0);
        r.final_output = (k == TAP_COUNT - 2);
        pending_outputs.push_back(r);
        shift_delay_line('0);
      end
      foreach (delay_line[k]) delay_line[k] = '0;
    end
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 15)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Holds valid high between back-to-back transfers; it only drops for a gap.
  task automatic send_sample(sample_t s, logic eob);
    if (sender_bursts && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= s;
    in_ch.end_of_block <= eob;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_outputs(s, eob);
    samples_sent++;
    if (eob) blocks_sent++;
  endtask

  task automatic send_block(int length);
    for (int i = 0; i < length; i++) begin
      send_sample(random_sample(), i == length - 1);
    end
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_outputs.size() != 0);
  endtask

  task automatic test_directed_extremes();
    sample_t values [7] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                            16'sh5555, 16'shaaaa};
    sender_bursts   = 1'b0;
    receiver_bursts = 1'b0;
    foreach (values[i]) send_sample(values[i], 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    // Signs follow the taps so the newest output reaches full scale.
    for (int i = 0; i < TAP_COUNT; i++) begin
      send_sample((i % 2 == 0) ? 16'sh8000 : 16'sh7fff, i == TAP_COUNT - 1);
    end
  endtask

  task automatic test_random_blocks();
    while (samples_sent < 170) begin
      sender_bursts   = ($urandom_range(0, 3) != 0);
      receiver_bursts = ($urandom_range(0, 3) != 0);
      send_block(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24));
    end
  endtask

  task automatic test_pause_mid_block();
    sender_bursts   = 1'b1;
    receiver_bursts = 1'b1;
    for (int i = 0; i < 6; i++) send_sample(random_sample(), 1'b0);
    wait_until_drained();
    for (int i = 0; i < 6; i++) send_sample(random_sample(), i == 5);
  endtask

  task automatic test_back_to_back();
    sender_bursts   = 1'b0;
    receiver_bursts = 1'b0;
    while (samples_sent < 225) begin
      send_block($urandom_range(1, 12));
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.end_of_block <= 1'b0;
    foreach (delay_line[k]) delay_line[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_blocks();
    test_pause_mid_block();
    test_back_to_back();
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples in %0d blocks, including full-scale and flush cases.",
             samples_sent, blocks_sent);
    $display("Checked %0d filtered outputs, found %0d mismatches.", outputs_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (receiver_bursts && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic void report_mismatch(string what, longint expected, longint actual);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on output %0d, %s: expected %0d, got %0d", outputs_checked, what,
               expected, actual);
    end
  endfunction

  always @(posedge clk_i) begin
    fir_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected transfer", 64'sd0, longint'(out_ch.filtered));
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.filtered !== want.filtered) begin
          report_mismatch("filtered", longint'(want.filtered), longint'(out_ch.filtered));
        end
        if (out_ch.final_output !== want.final_output) begin
          report_mismatch("final_output", longint'(want.final_output),
                          longint'(out_ch.final_output));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule
